>>> hdl/almf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package almf_pkg;

	localparam int BUFFER_BYTES_DEFAULT = 4096;
	localparam int INDEX_W = 12;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int MIN_CLOSE_INDEX = 12;
	localparam int STAR_WINDOW = 11;
	localparam int PREFIX_LEN = 8;

	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_NL = 8'h0A;

	typedef enum logic [0:0] {
		REG_ENABLE = 1'b0
	} reg_index_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h23;
			3'd1: c = 8'h52;
			3'd2: c = 8'h41;
			3'd3: c = 8'h4E;
			3'd4: c = 8'h47;
			3'd5: c = 8'h45;
			3'd6: c = 8'h41;
			3'd7: c = 8'h2C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> hdl/ascii_log_message_framer.sv
// A result is registered and appears in the cycle after its byte transaction is accepted.
// Throughput: one byte per cycle; the output register is refilled in the same
// cycle it is drained, so rx_ready falls only while a result is held back.
// Reset: arst_n clears enable, all framing state and the output valid at once.
// No clearing pass is needed; the block takes bytes straight after reset.
`timescale 1ns / 1ps
`default_nettype none
module ascii_log_message_framer #(
	parameter int BUFFER_BYTES = almf_pkg::BUFFER_BYTES_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [almf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [almf_pkg::PDATA_W-1:0] pwdata,
	output logic      [almf_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	input  wire logic                         rx_valid,
	output logic                              rx_ready,
	input  wire logic [7:0]                   rx_byte,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic      [7:0]                   out_byte,
	output logic                              stored,
	output logic      [almf_pkg::INDEX_W-1:0] byte_index,
	output logic                              frame_start,
	output logic                              frame_end,
	output logic                              prefix_match,
	output logic                              overflow
);
	import almf_pkg::*;

	localparam int LEN_W = $clog2(BUFFER_BYTES);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUFFER_BYTES - 1);
	localparam logic [LEN_W:0] WINDOW = (LEN_W + 1)'(STAR_WINDOW);
	localparam logic [LEN_W-1:0] CLOSE_MIN = LEN_W'(MIN_CLOSE_INDEX);
	localparam logic [LEN_W-1:0] PFX_LEN = LEN_W'(PREFIX_LEN);

	logic             enable_q;
	logic             framing_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] star_pos_q;
	logic             star_seen_q;
	logic             pfx_ok_q;

	logic             res_valid_q;
	logic [7:0]       out_byte_q;
	logic             stored_q;
	logic [INDEX_W-1:0] index_q;
	logic             start_q;
	logic             end_q;
	logic             pmatch_q;
	logic             ovf_q;

	logic             rx_fire;
	logic             cfg_wr;
	logic             cfg_sel;
	logic             enable_rise;

	logic             framing_d;
	logic [LEN_W-1:0] len_d;
	logic [LEN_W-1:0] star_pos_d;
	logic             star_seen_d;
	logic             pfx_ok_d;
	logic             st_stored;
	logic [LEN_W-1:0] st_idx;
	logic             st_start;
	logic             st_end;
	logic             st_pmatch;
	logic             st_ovf;
	logic             pfx_bad;
	logic             star_near;
	logic [LEN_W+INDEX_W-1:0] idx_wide;

	assign pready      = 1'b1;
	assign rx_ready    = !res_valid_q || res_ready;
	assign rx_fire     = rx_valid && rx_ready;
	assign cfg_sel     = paddr[2] == REG_ENABLE;
	assign cfg_wr      = psel && penable && pwrite && cfg_sel;
	assign enable_rise = cfg_wr && pwdata[0] && !enable_q;

	always_comb begin
		prdata = '0;
		if (cfg_sel) begin
			prdata[0] = enable_q;
		end
	end

	assign pfx_bad   = (len_q < PFX_LEN) && (rx_byte != prefix_char(len_q[2:0]));
	assign star_near = ({1'b0, star_pos_q} + WINDOW) >= {1'b0, len_q};

	always_comb begin
		framing_d   = framing_q;
		len_d       = len_q;
		star_pos_d  = star_pos_q;
		star_seen_d = star_seen_q;
		pfx_ok_d    = pfx_ok_q;
		st_stored   = 1'b0;
		st_idx      = '0;
		st_start    = 1'b0;
		st_end      = 1'b0;
		st_pmatch   = 1'b0;
		st_ovf      = 1'b0;
		if (enable_q) begin
			priority if (!framing_q) begin
				if (rx_byte == CHAR_HASH) begin
					framing_d   = 1'b1;
					len_d       = LEN_W'(1);
					star_seen_d = 1'b0;
					star_pos_d  = '0;
					pfx_ok_d    = 1'b1;
					st_stored   = 1'b1;
					st_start    = 1'b1;
				end
			end else if (len_q >= LEN_MAX) begin
				framing_d   = 1'b0;
				len_d       = '0;
				star_pos_d  = '0;
				star_seen_d = 1'b0;
				pfx_ok_d    = 1'b0;
				st_ovf      = 1'b1;
			end else begin
				st_stored = 1'b1;
				st_idx    = len_q;
				if (pfx_bad) begin
					pfx_ok_d = 1'b0;
				end
				if (rx_byte == CHAR_STAR) begin
					star_seen_d = 1'b1;
					star_pos_d  = len_q;
				end
				len_d = len_q + LEN_W'(1);
				if (rx_byte == CHAR_NL && len_q >= CLOSE_MIN && star_seen_q && star_near) begin
					st_end      = 1'b1;
					st_pmatch   = pfx_ok_d;
					framing_d   = 1'b0;
					len_d       = '0;
					star_pos_d  = '0;
					star_seen_d = 1'b0;
					pfx_ok_d    = 1'b0;
				end
			end
		end
	end

	assign idx_wide = {{INDEX_W{1'b0}}, st_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			framing_q   <= 1'b0;
			len_q       <= '0;
			star_pos_q  <= '0;
			star_seen_q <= 1'b0;
			pfx_ok_q    <= 1'b0;
		end else begin
			if (enable_rise) begin
				framing_q   <= 1'b0;
				len_q       <= '0;
				star_pos_q  <= '0;
				star_seen_q <= 1'b0;
				pfx_ok_q    <= 1'b0;
			end else if (rx_fire) begin
				framing_q   <= framing_d;
				len_q       <= len_d;
				star_pos_q  <= star_pos_d;
				star_seen_q <= star_seen_d;
				pfx_ok_q    <= pfx_ok_d;
			end
			if (cfg_wr) begin
				enable_q <= pwdata[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			out_byte_q <= rx_byte;
			stored_q   <= st_stored;
			index_q    <= idx_wide[INDEX_W-1:0];
			start_q    <= st_start;
			end_q      <= st_end;
			pmatch_q   <= st_pmatch;
			ovf_q      <= st_ovf;
		end
	end

	assign res_valid    = res_valid_q;
	assign out_byte     = out_byte_q;
	assign stored       = stored_q;
	assign byte_index   = index_q;
	assign frame_start  = start_q;
	assign frame_end    = end_q;
	assign prefix_match = pmatch_q;
	assign overflow     = ovf_q;

`ifndef SYNTH
	a_disabled_drops: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && !enable_q |=> res_valid && !stored && !frame_start)
		else $error("byte taken into a frame while disabled");

	a_full_overflows: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && enable_q && framing_q && len_q >= LEN_MAX |=> overflow && !stored)
		else $error("full frame did not overflow");

	a_hash_opens: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && enable_q && !framing_q && rx_byte == CHAR_HASH
		|=> framing_q && frame_start && stored && byte_index == '0)
		else $error("hash did not open a frame");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(byte_index))
		else $error("pending result changed");
`endif

endmodule
`default_nettype wire

>>> tb/ascii_log_message_framer_tb.sv
`timescale 1ns / 1ps
module ascii_log_message_framer_tb;
	import almf_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int FIRST_HOLD_AT = 300;
	localparam int SECOND_HOLD_AT = 4600;
	localparam int CALM_LO = 5000;
	localparam int CALM_HI = 5400;
	localparam int MAX_SHOWN = 10;
	localparam logic [63:0] RANGE_TAG = "#RANGEA,";

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               stored;
		logic [INDEX_W-1:0] byte_index;
		logic               frame_start;
		logic               frame_end;
		logic               prefix_match;
		logic               overflow;
	} framed_byte_t;

	typedef enum logic [0:0] {
		ROW_BYTE,
		ROW_ENABLE
	} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [7:0]   value;
		logic         typed;
		framed_byte_t want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               rx_valid;
	logic               rx_ready;
	logic [7:0]         rx_byte;
	logic               res_valid;
	logic               res_ready;
	logic [7:0]         out_byte;
	logic               stored;
	logic [INDEX_W-1:0] byte_index;
	logic               frame_start;
	logic               frame_end;
	logic               prefix_match;
	logic               overflow;

	ascii_log_message_framer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_ready(res_ready),
		.out_byte(out_byte), .stored(stored), .byte_index(byte_index),
		.frame_start(frame_start), .frame_end(frame_end),
		.prefix_match(prefix_match), .overflow(overflow)
	);

	// framer shadow state
	logic pr_enable;
	logic pr_framing;
	int   pr_len;
	int   pr_star_pos;
	logic pr_star_seen;
	logic pr_prefix_ok;

	framed_byte_t expected_q[$];
	stim_row_t    stim_rows[$];
	logic         use_typed;
	framed_byte_t typed_want;

	int accepted_cnt;
	int live_cnt;
	int mismatch_cnt;
	int shown_cnt;
	int closed_cnt;
	int prefix_cnt;
	int overflow_cnt;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
		$display("ascii_log_message_framer verification failed");
		$finish;
	end

	function automatic void frame_clear();
		pr_framing = 1'b0;
		pr_len = 0;
		pr_star_pos = 0;
		pr_star_seen = 1'b0;
		pr_prefix_ok = 1'b0;
	endfunction

	function automatic framed_byte_t frame_predict(input logic [7:0] b);
		framed_byte_t r;
		int n;
		r = {b, 17'b0};
		if (pr_enable) begin
			if (!pr_framing) begin
				if (b == CHAR_HASH) begin
					pr_framing = 1'b1;
					pr_len = 1;
					pr_star_seen = 1'b0;
					pr_star_pos = 0;
					pr_prefix_ok = 1'b1;
					r.stored = 1'b1;
					r.frame_start = 1'b1;
				end
			end else if (pr_len >= BUFFER_BYTES_DEFAULT - 1) begin
				frame_clear();
				r.overflow = 1'b1;
			end else begin
				n = pr_len;
				r.stored = 1'b1;
				r.byte_index = n[INDEX_W-1:0];
				if (n < PREFIX_LEN && b != RANGE_TAG[63-8*n -: 8])
					pr_prefix_ok = 1'b0;
				if (b == CHAR_STAR) begin
					pr_star_seen = 1'b1;
					pr_star_pos = n;
				end
				pr_len = n + 1;
				if (b == CHAR_NL && n >= MIN_CLOSE_INDEX && pr_star_seen &&
						pr_star_pos + STAR_WINDOW >= n) begin
					r.frame_end = 1'b1;
					r.prefix_match = pr_prefix_ok;
					frame_clear();
				end
			end
		end
		return r;
	endfunction

	function automatic framed_byte_t idle_result(input logic [7:0] b);
		return {b, 17'b0};
	endfunction

	function automatic bit calm_window();
		return accepted_cnt >= CALM_LO && accepted_cnt < CALM_HI;
	endfunction

	function automatic logic [7:0] body_char();
		int pick;
		pick = $urandom_range(0, 39);
		if (pick == 0)
			return CHAR_STAR;
		if (pick == 1)
			return CHAR_HASH;
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	task automatic note_fault(input string tag, input framed_byte_t w, input framed_byte_t g);
		mismatch_cnt++;
		if (shown_cnt < MAX_SHOWN) begin
			shown_cnt++;
			$display("%0s: want %02h st%b ix%0d fs%b fe%b pm%b ov%b, got %02h st%b ix%0d fs%b fe%b pm%b ov%b",
				tag, w.out_byte, w.stored, w.byte_index, w.frame_start, w.frame_end,
				w.prefix_match, w.overflow, g.out_byte, g.stored, g.byte_index,
				g.frame_start, g.frame_end, g.prefix_match, g.overflow);
		end
	endtask

	// byte transactions accepted
	always @(posedge clk) begin
		framed_byte_t p;
		if (arst_n && rx_valid && rx_ready) begin
			if (pr_enable)
				live_cnt++;
			p = frame_predict(rx_byte);
			expected_q.insert(expected_q.size(), use_typed ? typed_want : p);
			accepted_cnt++;
		end
	end

	// result transactions
	always @(posedge clk) begin
		framed_byte_t g;
		framed_byte_t w;
		if (arst_n && res_valid && res_ready) begin
			g = {out_byte, stored, byte_index, frame_start, frame_end, prefix_match, overflow};
			if (expected_q.size() == 0) begin
				note_fault("stray result", 25'b0, g);
			end else begin
				w = expected_q.pop_front();
				if (g !== w)
					note_fault("mismatch", w, g);
			end
			if (g.frame_end === 1'b1)
				closed_cnt++;
			if (g.frame_end === 1'b1 && g.prefix_match === 1'b1)
				prefix_cnt++;
			if (g.overflow === 1'b1)
				overflow_cnt++;
		end
	end

	// receiver: random stalls, two long hold-offs, one calm window
	initial begin
		int hold_left;
		int holds_done;
		res_ready = 1'b0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_done < 2 &&
					accepted_cnt >= (holds_done == 0 ? FIRST_HOLD_AT : SECOND_HOLD_AT)) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (calm_window()) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= ($urandom_range(0, 99) >= 26);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic typed, input framed_byte_t w);
		if (!calm_window() && $urandom_range(0, 99) < 26) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		use_typed = typed;
		typed_want = w;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		rx_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// write enable, then read it back
	task automatic enable_set(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_ENABLE, 2'b00};
		pwdata <= {{(PDATA_W-1){1'b0}}, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (v && !pr_enable)
			frame_clear();
		pr_enable = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== pr_enable) begin
			mismatch_cnt++;
			if (shown_cnt < MAX_SHOWN) begin
				shown_cnt++;
				$display("enable readback: want %b, got %b", pr_enable, prdata[0]);
			end
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b);
		stim_rows.insert(stim_rows.size(), {ROW_BYTE, b, 1'b0, 25'b0});
	endtask

	task automatic add_checked(input logic [7:0] b, input framed_byte_t w);
		stim_rows.insert(stim_rows.size(), {ROW_BYTE, b, 1'b1, w});
	endtask

	task automatic add_enable(input logic v);
		stim_rows.insert(stim_rows.size(), {ROW_ENABLE, {7'b0, v}, 1'b0, 25'b0});
	endtask

	// mostly well-formed lines with random content, some broken, some noise
	task automatic send_log_line();
		logic [7:0] line_q[$];
		int kind;
		int body;
		int pos;
		int i;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 8))
				line_q.insert(line_q.size(), 8'($urandom));
		end else begin
			line_q.insert(line_q.size(), CHAR_HASH);
			if (kind != 8) begin
				pos = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 7) : 0;
				for (i = 1; i < PREFIX_LEN; i++)
					line_q.insert(line_q.size(),
						i == pos ? 8'($urandom) : RANGE_TAG[63-8*i -: 8]);
			end
			body = (kind == 8) ? $urandom_range(0, 3) : $urandom_range(2, 24);
			repeat (body)
				line_q.insert(line_q.size(), body_char());
			if (kind != 7) begin
				line_q.insert(line_q.size(), CHAR_STAR);
				repeat ($urandom_range(0, 11))
					line_q.insert(line_q.size(), body_char());
			end
			line_q.insert(line_q.size(), CHAR_NL);
		end
		foreach (line_q[k])
			send_byte(line_q[k], 1'b0, 25'b0);
	endtask

	initial begin
		int i;
		int cfg_mark;
		int live_base;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		use_typed = 1'b0;
		typed_want = '0;
		accepted_cnt = 0;
		live_cnt = 0;
		mismatch_cnt = 0;
		shown_cnt = 0;
		closed_cnt = 0;
		prefix_cnt = 0;
		overflow_cnt = 0;
		pr_enable = 1'b0;
		frame_clear();

		add_checked(CHAR_HASH, idle_result(CHAR_HASH));
		add_checked(8'hFF, idle_result(8'hFF));
		add_enable(1'b1);
		add_checked(8'h00, idle_result(8'h00));
		add_checked(8'hFF, idle_result(8'hFF));
		add_checked(CHAR_HASH, {CHAR_HASH, 1'b1, 12'd0, 1'b1, 3'b000});
		for (i = 1; i < PREFIX_LEN; i++)
			add_byte(RANGE_TAG[63-8*i -: 8]);
		add_byte(CHAR_HASH);
		add_byte(CHAR_STAR);
		add_byte(CHAR_NL);
		add_byte("x");
		add_checked(CHAR_NL, {CHAR_NL, 1'b1, 12'd12, 1'b0, 1'b1, 1'b1, 1'b0});
		add_checked(CHAR_HASH, {CHAR_HASH, 1'b1, 12'd0, 1'b1, 3'b000});
		add_byte("Q");
		add_enable(1'b1);
		add_byte(CHAR_NL);
		add_enable(1'b0);
		add_checked(CHAR_HASH, idle_result(CHAR_HASH));
		add_enable(1'b1);
		add_checked("x", idle_result("x"));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[r]) begin
			if (stim_rows[r].kind == ROW_ENABLE) begin
				settle();
				enable_set(stim_rows[r].value[0]);
			end else begin
				send_byte(stim_rows[r].value, stim_rows[r].typed, stim_rows[r].want);
			end
		end

		// fill one frame to capacity, then the next byte overflows
		send_byte(CHAR_HASH, 1'b0, 25'b0);
		repeat (BUFFER_BYTES_DEFAULT - 2)
			send_byte(body_char(), 1'b0, 25'b0);
		send_byte(CHAR_HASH, 1'b1, {CHAR_HASH, 16'b0, 1'b1});

		live_base = live_cnt;
		cfg_mark = live_cnt;
		while (live_cnt - live_base < RANDOM_ITEMS) begin
			send_log_line();
			if (live_cnt - cfg_mark >= 200) begin
				cfg_mark = live_cnt;
				settle();
				if ($urandom_range(0, 9) < 6) begin
					enable_set(1'b1);
				end else begin
					enable_set(1'b0);
					repeat ($urandom_range(1, 6))
						send_byte(8'($urandom), 1'b0, 25'b0);
					settle();
					enable_set(1'b1);
				end
			end
		end

		rx_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d byte transactions, %0d lines closed (%0d with range prefix), %0d overflows",
			accepted_cnt, closed_cnt, prefix_cnt, overflow_cnt);
		$display("%0d mismatches, %0d results outstanding", mismatch_cnt, expected_q.size());
		if (mismatch_cnt == 0 && expected_q.size() == 0) begin
			$display("ascii_log_message_framer verification clean");
		end else begin
			$display("ascii_log_message_framer verification failed");
		end
		$finish;
	end

endmodule
